@@ hw/rtl/tle_pkg.sv @@
`default_nettype none

package tle_pkg;

  localparam int unsigned LEN_W = 24;
  localparam logic [LEN_W-1:0] LEN_MAX = 24'hFFFFFF;

  localparam logic [7:0] CODE_LETTER_FIRST = 8'h41;
  localparam logic [7:0] CODE_LETTER_LAST  = 8'h5A;
  localparam logic [7:0] CODE_DIGIT_FIRST  = 8'h30;
  localparam logic [7:0] CODE_DIGIT_LAST   = 8'h39;
  localparam logic [5:0] DIGIT_SLOT_BASE   = 6'd26;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CITY = 1'b1;

  typedef struct packed {
    logic       command;
    logic [5:0] slot;
    logic [9:0] x_coord;
    logic [9:0] y_coord;
    logic [7:0] city_code;
    logic       last_city;
  } tle_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] tour_length;
    logic             bad_city;
  } tle_out_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] idx;
  } tle_slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ACC,
    ST_FINISH
  } tle_state_e;

  function automatic tle_slot_t code_to_slot(logic [7:0] code);
    tle_slot_t r;
    r.valid = 1'b0;
    r.idx   = '0;
    if (code >= CODE_LETTER_FIRST && code <= CODE_LETTER_LAST) begin
      r.valid = 1'b1;
      r.idx   = 6'(code - CODE_LETTER_FIRST);
    end else if (code >= CODE_DIGIT_FIRST && code <= CODE_DIGIT_LAST) begin
      r.valid = 1'b1;
      r.idx   = 6'(code - CODE_DIGIT_FIRST) + DIGIT_SLOT_BASE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tour_length_evaluator.sv @@
// Tour length evaluator.
// The input channel (in_valid_i, in_stall_o, in_data_i) carries load and city
// transactions. A load transaction writes the x and y of one table slot, if
// the slot lies inside the table. A city transaction looks up its slot and
// adds the Euclidean distance from the previous point, starting at the origin,
// as fixed point with FRACTION_BITS fraction bits; the total saturates.
// A city transaction with a valid code occupies the block from acceptance to
// the next acceptance, through the table read, difference, two squarings on
// one shared multiplier, a bit-serial square root that resolves one result
// bit per cycle, and the accumulate. An invalid city code only sets the error
// flag. After the last city of a tour the block enters its finish step, at
// whose end its output transaction (out_valid_o, out_stall_i, out_data_o) is
// raised and the running sum, error flag and previous point are cleared.
// The result sits in an output register, so the block keeps working while
// the receiver stalls; it waits only when a further tour ends before the
// held result is taken.
// Reset clears the control state and the running sum; the coordinate table
// holds no defined value until each slot is loaded.
`default_nettype none

module tour_length_evaluator #(
  parameter int unsigned CITY_COUNT    = 36,
  parameter int unsigned COORD_BITS    = 10,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire tle_pkg::tle_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tle_pkg::tle_out_t      out_data_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned AW    = $clog2(CITY_COUNT);
  localparam int unsigned QW    = CW + FRACTION_BITS + 1;
  localparam int unsigned RAD_W = 2 * QW;
  localparam int unsigned CNT_W = $clog2(QW + 1);
  localparam int unsigned SUM_W = ((QW > tle_pkg::LEN_W) ? QW : tle_pkg::LEN_W) + 1;

  tle_pkg::tle_state_e state_q, state_d;

  logic [2*CW-1:0] mem [CITY_COUNT];
  logic [2*CW-1:0] rd_q;
  logic [CW-1:0]   prev_x_q, prev_y_q;
  logic [CW-1:0]   dx_q, dy_q;
  logic [2*CW-1:0] sq_q;
  logic [RAD_W-1:0] rad_q;
  logic [QW+1:0]   rem_q;
  logic [QW-1:0]   root_q;
  logic [CNT_W-1:0] cnt_q;
  logic [tle_pkg::LEN_W-1:0] len_q;
  logic            err_q;
  logic            last_q;
  logic            out_valid_q;
  tle_pkg::tle_out_t out_q;

  logic            in_fire;
  logic            is_load;
  logic            load_ok;
  logic            city_ok;
  tle_pkg::tle_slot_t city_slot;
  logic [CW+9:0]   x_wide, y_wide;
  logic [CW-1:0]   rd_x, rd_y;
  logic [CW-1:0]   mul_a;
  logic [2*CW-1:0] prod;
  logic [QW+1:0]   rem_sh, trial;
  logic [SUM_W-1:0] sum;
  logic            emit;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign is_load   = (in_data_i.command == tle_pkg::CMD_LOAD);
  assign city_slot = tle_pkg::code_to_slot(in_data_i.city_code);
  assign load_ok   = ({1'b0, in_data_i.slot} < 7'(CITY_COUNT));
  assign city_ok   = city_slot.valid && ({1'b0, city_slot.idx} < 7'(CITY_COUNT));
  assign x_wide    = {{CW{1'b0}}, in_data_i.x_coord};
  assign y_wide    = {{CW{1'b0}}, in_data_i.y_coord};
  assign rd_x      = rd_q[2*CW-1:CW];
  assign rd_y      = rd_q[CW-1:0];
  assign mul_a     = (state_q == tle_pkg::ST_SQX) ? dx_q : dy_q;
  assign prod      = (2*CW)'(mul_a) * (2*CW)'(mul_a);
  assign rem_sh    = {rem_q[QW-1:0], rad_q[RAD_W-1 -: 2]};
  assign trial     = {root_q, 2'b01};
  assign sum       = SUM_W'(len_q) + SUM_W'(root_q);
  assign emit      = (state_q == tle_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (in_fire && is_load && load_ok) begin
      mem[in_data_i.slot[AW-1:0]] <= {x_wide[CW-1:0], y_wide[CW-1:0]};
    end
    if (in_fire && !is_load && city_ok) begin
      rd_q <= mem[city_slot.idx[AW-1:0]];
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    case (state_q)
      tle_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && !is_load) begin
          if (city_ok) begin
            state_d = tle_pkg::ST_FETCH;
          end else if (in_data_i.last_city) begin
            state_d = tle_pkg::ST_FINISH;
          end
        end
      end
      tle_pkg::ST_FETCH: state_d = tle_pkg::ST_SQX;
      tle_pkg::ST_SQX:   state_d = tle_pkg::ST_SQY;
      tle_pkg::ST_SQY:   state_d = tle_pkg::ST_ROOT;
      tle_pkg::ST_ROOT: begin
        if (cnt_q == CNT_W'(QW - 1)) begin
          state_d = tle_pkg::ST_ACC;
        end
      end
      tle_pkg::ST_ACC: begin
        state_d = last_q ? tle_pkg::ST_FINISH : tle_pkg::ST_IDLE;
      end
      tle_pkg::ST_FINISH: begin
        if (emit) begin
          state_d = tle_pkg::ST_IDLE;
        end
      end
      default: state_d = tle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tle_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      len_q       <= '0;
      err_q       <= 1'b0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        tle_pkg::ST_IDLE: begin
          if (in_fire && !is_load) begin
            last_q <= in_data_i.last_city;
            if (!city_ok) begin
              err_q <= 1'b1;
            end
          end
        end
        tle_pkg::ST_SQY: begin
          cnt_q <= '0;
        end
        tle_pkg::ST_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
        end
        tle_pkg::ST_ACC: begin
          len_q    <= (sum > SUM_W'(tle_pkg::LEN_MAX)) ? tle_pkg::LEN_MAX
                                                       : sum[tle_pkg::LEN_W-1:0];
          prev_x_q <= rd_x;
          prev_y_q <= rd_y;
        end
        tle_pkg::ST_FINISH: begin
          if (emit) begin
            prev_x_q    <= '0;
            prev_y_q    <= '0;
            len_q       <= '0;
            err_q       <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tle_pkg::ST_FETCH: begin
        dx_q <= (rd_x >= prev_x_q) ? rd_x - prev_x_q : prev_x_q - rd_x;
        dy_q <= (rd_y >= prev_y_q) ? rd_y - prev_y_q : prev_y_q - rd_y;
      end
      tle_pkg::ST_SQX: begin
        sq_q <= prod;
      end
      tle_pkg::ST_SQY: begin
        rad_q  <= RAD_W'({1'b0, sq_q} + {1'b0, prod}) << (2 * FRACTION_BITS);
        rem_q  <= '0;
        root_q <= '0;
      end
      tle_pkg::ST_ROOT: begin
        rad_q <= rad_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[QW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[QW-2:0], 1'b0};
        end
      end
      tle_pkg::ST_FINISH: begin
        if (emit) begin
          out_q.tour_length <= len_q;
          out_q.bad_city    <= err_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_root_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tle_pkg::ST_ROOT) |-> (cnt_q < CNT_W'(QW)))
    else $error("square root iteration count overran");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == tle_pkg::ST_FINISH))
    else $error("result raised outside the finish step");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (len_q == '0) && !err_q && (prev_x_q == '0) && (prev_y_q == '0))
    else $error("running state not cleared after a tour ended");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tle_pkg::ST_ROOT) |-> in_stall_o)
    else $error("input accepted while a distance is in progress");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !emit) |=> !out_valid_o)
    else $error("taken result stayed valid");

endmodule

`default_nettype wire

@@ sim/tour_length_checker.sv @@
module tour_length_checker #(
  parameter int unsigned CITY_COUNT    = 36,
  parameter int unsigned COORD_BITS    = 10,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  tle_pkg::tle_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  tle_pkg::tle_out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       due_count_o,
  output int unsigned       totals_checked_o,
  output int unsigned       flagged_tours_o,
  output int unsigned       saturated_tours_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [9:0] COORD_MASK = 10'((1 << COORD_BITS) - 1);

  logic [9:0]                city_x [CITY_COUNT];
  logic [9:0]                city_y [CITY_COUNT];
  logic [9:0]                here_x;
  logic [9:0]                here_y;
  logic [tle_pkg::LEN_W-1:0] running_total;
  logic                      saw_bad_code;
  tle_pkg::tle_out_t         totals_due [$];
  tle_pkg::tle_out_t         oldest;

  function automatic logic [31:0] floor_root(input logic [63:0] rad);
    logic [31:0] root;
    logic [31:0] trial;
    logic [63:0] square;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial  = root | (32'd1 << b);
      square = {32'b0, trial} * {32'b0, trial};
      if (square <= rad) root = trial;
    end
    return root;
  endfunction

  task automatic predict_total(input tle_pkg::tle_in_t t);
    logic [7:0]        offset;
    logic [5:0]        idx;
    logic              known;
    logic [9:0]        dx;
    logic [9:0]        dy;
    logic [63:0]       rad;
    logic [63:0]       sum;
    tle_pkg::tle_out_t total;
    if (t.command == tle_pkg::CMD_LOAD) begin
      if (t.slot < CITY_COUNT) begin
        city_x[t.slot] = t.x_coord & COORD_MASK;
        city_y[t.slot] = t.y_coord & COORD_MASK;
      end
    end else begin
      known = 1'b0;
      idx   = '0;
      if (t.city_code >= tle_pkg::CODE_LETTER_FIRST &&
          t.city_code <= tle_pkg::CODE_LETTER_LAST) begin
        offset = t.city_code - tle_pkg::CODE_LETTER_FIRST;
        idx    = offset[5:0];
        known  = 1'b1;
      end else if (t.city_code >= tle_pkg::CODE_DIGIT_FIRST &&
                   t.city_code <= tle_pkg::CODE_DIGIT_LAST) begin
        offset = t.city_code - tle_pkg::CODE_DIGIT_FIRST + {2'b0, tle_pkg::DIGIT_SLOT_BASE};
        idx    = offset[5:0];
        known  = 1'b1;
      end
      if (idx >= CITY_COUNT) known = 1'b0;

      if (!known) begin
        saw_bad_code = 1'b1;
      end else begin
        dx  = (city_x[idx] > here_x) ? city_x[idx] - here_x : here_x - city_x[idx];
        dy  = (city_y[idx] > here_y) ? city_y[idx] - here_y : here_y - city_y[idx];
        rad = {54'b0, dx} * {54'b0, dx} + {54'b0, dy} * {54'b0, dy};
        rad = rad << (2 * FRACTION_BITS);
        sum = {40'b0, running_total} + {32'b0, floor_root(rad)};
        running_total = (sum > {40'b0, tle_pkg::LEN_MAX}) ? tle_pkg::LEN_MAX
                                                          : sum[tle_pkg::LEN_W-1:0];
        here_x = city_x[idx];
        here_y = city_y[idx];
      end

      if (t.last_city) begin
        total.tour_length = running_total;
        total.bad_city    = saw_bad_code;
        totals_due        = {totals_due, total};
        if (running_total == tle_pkg::LEN_MAX) saturated_tours_o++;
        if (saw_bad_code) flagged_tours_o++;
        running_total = '0;
        saw_bad_code  = 1'b0;
        here_x        = '0;
        here_y        = '0;
      end
    end
  endtask

  // The result side is handled first: a result taken at an edge can never
  // belong to the transaction accepted at that same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CITY_COUNT; i++) begin
        city_x[i] = '0;
        city_y[i] = '0;
      end
      here_x            = '0;
      here_y            = '0;
      running_total     = '0;
      saw_bad_code      = 1'b0;
      totals_due.delete();
      fail_count_o      = 0;
      due_count_o       = 0;
      totals_checked_o  = 0;
      flagged_tours_o   = 0;
      saturated_tours_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (totals_due.size() == 0) begin
          $display("%0t: tour total with none expected: expected nothing, got length %h bad %b",
                   $time, out_data_i.tour_length, out_data_i.bad_city);
          fail_count_o++;
        end else begin
          oldest = totals_due.pop_front();
          totals_checked_o++;
          if (oldest.tour_length !== out_data_i.tour_length) begin
            $display("%0t: tour_length mismatch: expected %h, got %h",
                     $time, oldest.tour_length, out_data_i.tour_length);
            fail_count_o++;
          end
          if (oldest.bad_city !== out_data_i.bad_city) begin
            $display("%0t: bad_city mismatch: expected %b, got %b",
                     $time, oldest.bad_city, out_data_i.bad_city);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_total(in_data_i);
      due_count_o = totals_due.size();
    end
  end

endmodule

@@ sim/tour_length_evaluator_tb.sv @@
module tour_length_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CITY_COUNT      = 36;
  localparam int unsigned ITEM_TARGET     = 850;
  localparam int unsigned IDLE_PERCENT    = 16;
  localparam int unsigned HOLD_AFTER      = 10;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned SATURATING_LEGS = 48;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              out_stall = 1'b0;
  tle_pkg::tle_in_t  in_data   = '0;
  logic              in_stall;
  logic              out_valid;
  tle_pkg::tle_out_t out_data;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned totals_checked;
  int unsigned flagged_tours;
  int unsigned saturated_tours;
  int unsigned loads_sent  = 0;
  int unsigned cities_sent = 0;
  bit          slot_loaded [CITY_COUNT];

  tour_length_evaluator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tour_length_checker tour_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_i        (out_data),
    .fail_count_o      (fail_count),
    .due_count_o       (due_count),
    .totals_checked_o  (totals_checked),
    .flagged_tours_o   (flagged_tours),
    .saturated_tours_o (saturated_tours)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic tle_pkg::tle_in_t noise_item();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[$bits(tle_pkg::tle_in_t)-1:0];
  endfunction

  function automatic logic [9:0] random_coord();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return 10'h3FF;
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [7:0] city_code_of(input logic [5:0] s);
    if (s < tle_pkg::DIGIT_SLOT_BASE) return tle_pkg::CODE_LETTER_FIRST + {2'b0, s};
    return tle_pkg::CODE_DIGIT_FIRST + {2'b0, s - tle_pkg::DIGIT_SLOT_BASE};
  endfunction

  function automatic logic [5:0] pick_loaded_slot();
    logic [5:0] s;
    do s = 6'($urandom_range(0, CITY_COUNT - 1)); while (!slot_loaded[s]);
    return s;
  endfunction

  // Mostly codes of loaded cities; otherwise any byte, as long as it does not
  // name a city whose coordinates were never written.
  function automatic logic [7:0] tour_code();
    logic [7:0]         code;
    tle_pkg::tle_slot_t hit;
    code = city_code_of(pick_loaded_slot());
    if ($urandom_range(0, 99) < 8) begin
      code = 8'($urandom_range(0, 255));
      hit  = tle_pkg::code_to_slot(code);
      if (hit.valid && !slot_loaded[hit.idx]) code = city_code_of(pick_loaded_slot());
    end
    return code;
  endfunction

  task automatic send_item(input tle_pkg::tle_in_t t);
    while (!((loads_sent + cities_sent) >= 300 && (loads_sent + cities_sent) < 450) &&
           $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_slot(input logic [5:0] s, input logic [9:0] x, input logic [9:0] y);
    tle_pkg::tle_in_t t;
    t         = noise_item();
    t.command = tle_pkg::CMD_LOAD;
    t.slot    = s;
    t.x_coord = x;
    t.y_coord = y;
    send_item(t);
    if (s < CITY_COUNT) begin
      slot_loaded[s] = 1'b1;
      loads_sent++;
    end
  endtask

  task automatic visit_city(input logic [7:0] code, input logic last);
    tle_pkg::tle_in_t t;
    t           = noise_item();
    t.command   = tle_pkg::CMD_CITY;
    t.city_code = code;
    t.last_city = last;
    send_item(t);
    cities_sent++;
  endtask

  task automatic random_tour(input int unsigned legs);
    for (int unsigned i = 1; i <= legs; i++) begin
      if ($urandom_range(0, 99) < 4)
        load_slot(6'($urandom_range(0, CITY_COUNT - 1)), random_coord(), random_coord());
      visit_city(tour_code(), i == legs);
    end
  endtask

  initial begin : stimulus
    int unsigned chunk;
    int unsigned roll;
    logic [5:0]  near_slot;
    logic [5:0]  far_slot;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_slot(6'd0, 10'h3FF, 10'h3FF);
    load_slot(6'd25, 10'h3FF, '0);
    load_slot(6'd26, '0, 10'h3FF);
    load_slot(6'd35, '0, '0);
    load_slot(6'd1, 10'd3, 10'd4);
    load_slot(6'd63, 10'h2AA, 10'h155);
    load_slot(6'd36, 10'h155, 10'h2AA);

    visit_city(city_code_of(6'd1), 1'b1);

    // Corner to corner, ending back at the origin without a closing leg.
    visit_city(city_code_of(6'd0), 1'b0);
    visit_city(city_code_of(6'd25), 1'b0);
    visit_city(city_code_of(6'd26), 1'b0);
    visit_city(city_code_of(6'd35), 1'b1);

    // An invalid code in the middle, then a zero-length leg.
    visit_city(city_code_of(6'd0), 1'b0);
    visit_city("#", 1'b0);
    visit_city(city_code_of(6'd0), 1'b0);
    visit_city(city_code_of(6'd1), 1'b1);

    // Invalid last city still closes the tour.
    visit_city(city_code_of(6'd35), 1'b0);
    visit_city("z", 1'b1);
    visit_city(8'hFF, 1'b1);

    // Codes just outside each valid range.
    visit_city(8'h00, 1'b0);
    visit_city(tle_pkg::CODE_LETTER_FIRST - 8'd1, 1'b0);
    visit_city(tle_pkg::CODE_LETTER_LAST + 8'd1, 1'b0);
    visit_city(tle_pkg::CODE_DIGIT_FIRST - 8'd1, 1'b0);
    visit_city(tle_pkg::CODE_DIGIT_LAST + 8'd1, 1'b0);
    visit_city(city_code_of(6'd26), 1'b1);

    chunk = 0;
    while (loads_sent + cities_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (chunk == 30 || roll == 0) begin
        near_slot = 6'($urandom_range(0, CITY_COUNT - 1));
        do far_slot = 6'($urandom_range(0, CITY_COUNT - 1)); while (far_slot == near_slot);
        load_slot(near_slot, '0, '0);
        load_slot(far_slot, 10'h3FF, 10'h3FF);
        for (int unsigned leg = 1; leg <= SATURATING_LEGS; leg++)
          visit_city(city_code_of(leg[0] ? far_slot : near_slot), leg == SATURATING_LEGS);
      end else if (roll < 22) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 99) < 85)
            load_slot(6'($urandom_range(0, CITY_COUNT - 1)), random_coord(), random_coord());
          else
            load_slot(6'($urandom_range(CITY_COUNT, 63)), random_coord(), random_coord());
        end
      end else begin
        random_tour($urandom_range(1, 8));
      end
      chunk++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Drove %0d table loads and %0d tour cities, with out-of-table loads and bad codes.",
             loads_sent, cities_sent);
    $display("Checked %0d tour totals: %0d flagged bad, %0d saturated, one long output hold.",
             totals_checked, flagged_tours, saturated_tours);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned cycle_no;
    int unsigned taken;
    int unsigned hold_left;
    bit          held;
    cycle_no  = 0;
    taken     = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (out_valid && !out_stall) taken++;
      if (!held && taken == HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (cycle_no >= 5000 && cycle_no < 8000) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timed out after %0d cycles without a transaction.", quiet);
    $display("== FAIL ==");
    $finish;
  end

endmodule
